>>> design/cartridge_bank_controller_unit_defines.svh
// Assertion macros for the cartridge bank controller.
// Uses the including module's clock and reset signals.
`ifndef CARTRIDGE_BANK_CONTROLLER_UNIT_DEFINES_SVH
`define CARTRIDGE_BANK_CONTROLLER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define CBC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define CBC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define CBC_ASSERT(lbl, prop, msg)
`define CBC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> design/cbc_pkg.sv
// Shared types and constants for the cartridge bank controller.
// No dependencies.
package cbc_pkg;

   localparam int ADDR_W = 16;
   localparam int VALUE_W = 8;
   localparam int CTRL_W = 3;
   localparam int RSP_PAD_W = 6;

   localparam logic [CTRL_W-1:0] CTRL_NONE     = 3'd0;
   localparam logic [CTRL_W-1:0] CTRL_TYPE1_ROM = 3'd1;
   localparam logic [CTRL_W-1:0] CTRL_TYPE1_RAM = 3'd2;
   localparam logic [CTRL_W-1:0] CTRL_TYPE3    = 3'd3;
   localparam logic [CTRL_W-1:0] CTRL_TYPE5    = 3'd4;

   typedef struct packed {
      logic       rom_mode;
      logic [6:0] t1_rom_bank;
      logic [7:0] t5_bank_low;
      logic [7:0] t5_bank_high;
   } bank_state_type;

   // first field in the highest bits
   typedef struct packed {
      logic        timer_unsupported;
      logic        ram_enable;
      logic        ram_enable_set;
      logic [3:0]  ram_bank;
      logic        ram_bank_load;
      logic [15:0] rom_bank;
      logic        rom_bank_load;
      logic        claimed;
   } result_type;

endpackage

>>> design/cbc_decode.sv
// Write decoder: turns one CPU write into a result and the next bank state.
// Depends on cbc_pkg.
module cbc_decode (
   input  logic [cbc_pkg::CTRL_W-1:0]  ctrl_type,
   input  cbc_pkg::bank_state_type     state,
   input  logic [cbc_pkg::ADDR_W-1:0]  address,
   input  logic [cbc_pkg::VALUE_W-1:0] value,
   output cbc_pkg::result_type         result,
   output cbc_pkg::bank_state_type     state_next
);

   logic       both;
   logic       hi;
   logic       lo;
   logic       val_zero;
   logic       is_type1;
   logic [6:0] t1_bank;

   assign both = address[14] & address[13];
   assign hi = address[14];
   assign lo = address[13];
   assign val_zero = (value == '0);
   assign is_type1 = (ctrl_type == cbc_pkg::CTRL_TYPE1_ROM) ||
                     (ctrl_type == cbc_pkg::CTRL_TYPE1_RAM);

   always_comb begin
      result = '0;
      state_next = state;
      t1_bank = state.t1_rom_bank;
      if (is_type1 && !address[15]) begin
         result.claimed = 1'b1;
         if (both) begin
            state_next.rom_mode = val_zero;
         end else if (hi) begin
            if (state.rom_mode) begin
               t1_bank = {value[1:0], state.t1_rom_bank[4:0]};
               state_next.t1_rom_bank = t1_bank;
               result.rom_bank_load = 1'b1;
               result.rom_bank = {9'd0, t1_bank};
            end else begin
               result.ram_bank_load = 1'b1;
               result.ram_bank = {2'd0, value[1:0]};
            end
         end else if (lo) begin
            t1_bank = {state.t1_rom_bank[6:5], (val_zero ? 5'd1 : value[4:0])};
            state_next.t1_rom_bank = t1_bank;
            result.rom_bank_load = 1'b1;
            result.rom_bank = {9'd0, t1_bank};
         end else begin
            result.ram_enable_set = 1'b1;
            result.ram_enable = !val_zero;
         end
      end else if (ctrl_type == cbc_pkg::CTRL_TYPE3 && !address[15]) begin
         result.claimed = 1'b1;
         if (both) begin
            result.timer_unsupported = 1'b1;
         end else if (hi) begin
            result.ram_bank_load = 1'b1;
            result.ram_bank = {2'd0, value[1:0]};
         end else if (lo) begin
            result.rom_bank_load = 1'b1;
            result.rom_bank = val_zero ? 16'd1 : {9'd0, value[6:0]};
         end else begin
            result.ram_enable_set = 1'b1;
            result.ram_enable = !val_zero;
         end
      end else if (ctrl_type == cbc_pkg::CTRL_TYPE5 && !address[15] && !both) begin
         result.claimed = 1'b1;
         if (hi) begin
            result.ram_bank_load = 1'b1;
            result.ram_bank = value[3:0];
         end else if (address[13] && address[12]) begin
            state_next.t5_bank_high = value;
            result.rom_bank_load = 1'b1;
            result.rom_bank = {value, state.t5_bank_low};
         end else if (lo) begin
            state_next.t5_bank_low = value;
            result.rom_bank_load = 1'b1;
            result.rom_bank = {state.t5_bank_high, value};
         end else begin
            result.ram_enable_set = 1'b1;
            result.ram_enable = !val_zero;
         end
      end
   end

endmodule

>>> design/cbc_bank_state.sv
// Controller type register and banking state registers.
// Depends on cbc_pkg.
module cbc_bank_state (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write,
   input  logic [cbc_pkg::CTRL_W-1:0] csr_data,
   input  logic                       update,
   input  cbc_pkg::bank_state_type    state_next,
   output logic [cbc_pkg::CTRL_W-1:0] ctrl_type,
   output cbc_pkg::bank_state_type    state
);

   logic [cbc_pkg::CTRL_W-1:0] ctrl_type_ff;
   logic [cbc_pkg::CTRL_W-1:0] ctrl_type_in;
   cbc_pkg::bank_state_type    state_ff;
   cbc_pkg::bank_state_type    state_in;

   always_comb begin
      ctrl_type_in = ctrl_type_ff;
      state_in = state_ff;
      priority if (csr_write) begin
         ctrl_type_in = csr_data;
         state_in = '0;
         state_in.rom_mode = (csr_data != cbc_pkg::CTRL_TYPE1_RAM);
      end else if (update) begin
         state_in = state_next;
      end else begin
         state_in = state_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_type_ff <= cbc_pkg::CTRL_NONE;
         state_ff <= '{rom_mode: 1'b1, t1_rom_bank: '0, t5_bank_low: '0, t5_bank_high: '0};
      end else begin
         ctrl_type_ff <= ctrl_type_in;
         state_ff <= state_in;
      end
   end

   assign ctrl_type = ctrl_type_ff;
   assign state = state_ff;

endmodule

>>> design/cartridge_bank_controller_unit.sv
// A request is held in the input registers, then its result in the result registers.
// Throughput: one request per cycle unless rsp_tready stalls; they decouple both sides.
// The decoder and bank state update sit between the input and result registers.
// Reset (synchronous, active high) clears valids, type to none, state to defaults.
// Depends on cbc_pkg, cbc_decode, cbc_bank_state and the defines header.
`include "cartridge_bank_controller_unit_defines.svh"
module cartridge_bank_controller_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [23:0]                req_tdata,  // address[15:0], value[23:16]
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // claimed, rom_bank_load, rom_bank[17:2], ram_bank_load, ram_bank[22:19],
   // ram_enable_set, ram_enable, timer_unsupported[25], zero pad
   output logic [31:0]                rsp_tdata,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [cbc_pkg::CTRL_W-1:0] csr_data
);

   logic                        s1_valid_ff;
   logic                        s1_valid_in;
   logic [cbc_pkg::ADDR_W-1:0]  s1_addr_ff;
   logic [cbc_pkg::VALUE_W-1:0] s1_value_ff;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   cbc_pkg::result_type         rsp_data_ff;
   logic                        s2_ready;
   logic                        advance;
   logic                        req_take;
   logic [cbc_pkg::CTRL_W-1:0]  ctrl_type;
   cbc_pkg::bank_state_type     state;
   cbc_pkg::bank_state_type     state_next;
   cbc_pkg::result_type         result;

   assign s2_ready = !rsp_valid_ff || rsp_tready;
   assign advance = s1_valid_ff && s2_ready;
   assign req_tready = !s1_valid_ff || s2_ready;
   assign req_take = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   assign s1_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s2_ready ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_addr_ff <= req_tdata[15:0];
         s1_value_ff <= req_tdata[23:16];
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   cbc_bank_state u_state (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_valid && csr_ready),
      .csr_data   (csr_data),
      .update     (advance),
      .state_next (state_next),
      .ctrl_type  (ctrl_type),
      .state      (state)
   );

   cbc_decode u_decode (
      .ctrl_type  (ctrl_type),
      .state      (state),
      .address    (s1_addr_ff),
      .value      (s1_value_ff),
      .result     (result),
      .state_next (state_next)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {{cbc_pkg::RSP_PAD_W{1'b0}}, rsp_data_ff};

   `CBC_ASSERT(a_unclaimed_zero, (rsp_tvalid && !rsp_data_ff.claimed) |-> (rsp_tdata == '0), "unclaimed request with nonzero result")
   `CBC_ASSERT(a_strobe_onehot, !rsp_tvalid || $onehot0({rsp_data_ff.rom_bank_load, rsp_data_ff.ram_bank_load, rsp_data_ff.ram_enable_set, rsp_data_ff.timer_unsupported}), "more than one strobe set")
   `CBC_ASSERT(a_stall_blocks_input, (s1_valid_ff && rsp_tvalid && !rsp_tready) |-> !req_tready, "request taken while pipeline stalled")
   `CBC_ASSERT_NEXT(a_csr_restart, csr_valid, (state.t1_rom_bank == '0) && (state.t5_bank_low == '0) && (state.t5_bank_high == '0), "bank state not restarted after type write")

endmodule

>>> tb/cartridge_bank_controller_unit_tb.sv
// Self-checking testbench for cartridge_bank_controller_unit: random and directed CPU writes
// checked against an in-bench predictor of the bank controller decode and state.
// Depends on cbc_pkg and the cartridge_bank_controller_unit RTL.
`timescale 1ns / 1ps
module cartridge_bank_controller_unit_tb;

   localparam logic [cbc_pkg::CTRL_W-1:0] CTRL_RSVD_5 = 3'd5;
   localparam logic [cbc_pkg::CTRL_W-1:0] CTRL_RSVD_6 = 3'd6;
   localparam logic [cbc_pkg::CTRL_W-1:0] CTRL_RSVD_7 = 3'd7;
   localparam int WRITES_PER_PHASE = 70;
   localparam int LONG_HOLD_CYCLES = 250;

   typedef struct packed {
      logic [cbc_pkg::ADDR_W-1:0]  addr;
      logic [cbc_pkg::VALUE_W-1:0] val;
   } bus_write_type;

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [23:0]                req_tdata = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [31:0]                rsp_tdata;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [cbc_pkg::CTRL_W-1:0] csr_data = '0;

   bus_write_type              pending_writes[$];
   cbc_pkg::result_type        expected_results[$];
   logic [cbc_pkg::CTRL_W-1:0] ctrl_type;
   cbc_pkg::bank_state_type    bank;
   int             mismatches = 0;
   bit             req_fire = 1'b0;
   int             burst_left = 1;
   int             gap_left = 0;
   logic [15:0]    ready_pattern = 16'hFFFF;
   int             pattern_left = 0;
   int             hold_left = 0;
   int             hold_requests = 0;
   int             holds_served = 0;
   cbc_pkg::result_type got_r;
   cbc_pkg::result_type want_r;

   cartridge_bank_controller_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic void restart_bank_state();
      bank.rom_mode = (ctrl_type == cbc_pkg::CTRL_TYPE1_RAM) ? 1'b0 : 1'b1;
      bank.t1_rom_bank = '0;
      bank.t5_bank_low = '0;
      bank.t5_bank_high = '0;
   endfunction

   function automatic cbc_pkg::result_type decode_cpu_write(logic [15:0] addr, logic [7:0] val);
      cbc_pkg::result_type r;
      logic both, hi, lo;
      r = '0;
      both = addr[14] & addr[13];
      hi = addr[14];
      lo = addr[13];
      if ((ctrl_type == cbc_pkg::CTRL_TYPE1_ROM || ctrl_type == cbc_pkg::CTRL_TYPE1_RAM)
          && !addr[15]) begin
         r.claimed = 1'b1;
         if (both) begin
            bank.rom_mode = (val == 8'd0);
         end else if (hi) begin
            if (bank.rom_mode) begin
               bank.t1_rom_bank[6:5] = val[1:0];
               r.rom_bank_load = 1'b1;
               r.rom_bank = {9'd0, bank.t1_rom_bank};
            end else begin
               r.ram_bank_load = 1'b1;
               r.ram_bank = {2'b00, val[1:0]};
            end
         end else if (lo) begin
            bank.t1_rom_bank[4:0] = (val == 8'd0) ? 5'd1 : val[4:0];
            r.rom_bank_load = 1'b1;
            r.rom_bank = {9'd0, bank.t1_rom_bank};
         end else begin
            r.ram_enable_set = 1'b1;
            r.ram_enable = (val != 8'd0);
         end
      end else if (ctrl_type == cbc_pkg::CTRL_TYPE3 && !addr[15]) begin
         r.claimed = 1'b1;
         if (both) begin
            r.timer_unsupported = 1'b1;
         end else if (hi) begin
            r.ram_bank_load = 1'b1;
            r.ram_bank = {2'b00, val[1:0]};
         end else if (lo) begin
            r.rom_bank_load = 1'b1;
            r.rom_bank = (val == 8'd0) ? 16'd1 : {9'd0, val[6:0]};
         end else begin
            r.ram_enable_set = 1'b1;
            r.ram_enable = (val != 8'd0);
         end
      end else if (ctrl_type == cbc_pkg::CTRL_TYPE5 && addr < 16'h6000) begin
         r.claimed = 1'b1;
         if (hi) begin
            r.ram_bank_load = 1'b1;
            r.ram_bank = val[3:0];
         end else if (addr[13] && addr[12]) begin
            bank.t5_bank_high = val;
            r.rom_bank_load = 1'b1;
            r.rom_bank = {bank.t5_bank_high, bank.t5_bank_low};
         end else if (lo) begin
            bank.t5_bank_low = val;
            r.rom_bank_load = 1'b1;
            r.rom_bank = {bank.t5_bank_high, bank.t5_bank_low};
         end else begin
            r.ram_enable_set = 1'b1;
            r.ram_enable = (val != 8'd0);
         end
      end
      return r;
   endfunction

   task automatic compare_field(input string field, input logic [15:0] got,
                                input logic [15:0] want);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         mismatches++;
      end
   endtask

   // response check, then request prediction
   always @(posedge clock) begin
      if (reset) begin
         ctrl_type = cbc_pkg::CTRL_NONE;
         restart_bank_state();
         expected_results.delete();
         req_fire = 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual %h", $time, rsp_tdata);
               mismatches++;
            end else begin
               want_r = expected_results.pop_front();
               got_r = cbc_pkg::result_type'(rsp_tdata[25:0]);
               compare_field("claimed", 16'(got_r.claimed), 16'(want_r.claimed));
               compare_field("rom_bank_load", 16'(got_r.rom_bank_load),
                             16'(want_r.rom_bank_load));
               compare_field("rom_bank", got_r.rom_bank, want_r.rom_bank);
               compare_field("ram_bank_load", 16'(got_r.ram_bank_load),
                             16'(want_r.ram_bank_load));
               compare_field("ram_bank", 16'(got_r.ram_bank), 16'(want_r.ram_bank));
               compare_field("ram_enable_set", 16'(got_r.ram_enable_set),
                             16'(want_r.ram_enable_set));
               compare_field("ram_enable", 16'(got_r.ram_enable), 16'(want_r.ram_enable));
               compare_field("timer_unsupported", 16'(got_r.timer_unsupported),
                             16'(want_r.timer_unsupported));
               compare_field("pad", 16'(rsp_tdata[31:26]), 16'd0);
            end
         end
         if (csr_valid && csr_ready) begin
            ctrl_type = csr_data;
            restart_bank_state();
         end
         req_fire = req_tvalid && req_tready;
         if (req_fire)
            expected_results.push_back(decode_cpu_write(req_tdata[15:0], req_tdata[23:16]));
      end
   end

   // request driver: bursts with random gaps
   always @(negedge clock) begin
      bus_write_type w;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_writes.size() > 0) begin
            w = pending_writes.pop_front();
            req_tdata <= {w.val, w.addr};
            req_tvalid <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response receiver: rotating stall pattern, plus long holds on request
   always @(negedge clock) begin
      if (hold_requests != holds_served) begin
         holds_served++;
         hold_left = LONG_HOLD_CYCLES;
      end
      if (pattern_left == 0) begin
         pattern_left = $urandom_range(20, 100);
         case ($urandom_range(0, 3))
            0: ready_pattern = 16'hFFFF;
            1: ready_pattern = 16'($urandom);
            2: ready_pattern = 16'($urandom | $urandom);
            default: ready_pattern = 16'($urandom & $urandom);
         endcase
      end else begin
         pattern_left--;
         ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ready_pattern[0];
      end
   end

   task automatic queue_write(input logic [15:0] addr, input logic [7:0] val);
      pending_writes.push_back('{addr: addr, val: val});
   endtask

   task automatic queue_random_writes(input int count);
      logic [15:0] addr;
      logic [7:0] val;
      repeat (count) begin
         if ($urandom_range(0, 9) < 7)
            addr = 16'(($urandom_range(0, 7) << 12) | $urandom_range(0, 16'h0FFF));
         else
            addr = 16'($urandom_range(0, 16'hFFFF));
         case ($urandom_range(0, 7))
            0: val = 8'h00;
            1: val = 8'h80;
            2: val = 8'hFF;
            3: val = 8'($urandom_range(0, 3));
            default: val = 8'($urandom_range(0, 255));
         endcase
         queue_write(addr, val);
      end
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (!(pending_writes.size() == 0 && !req_tvalid && expected_results.size() == 0));
   endtask

   task automatic set_controller_type(input logic [cbc_pkg::CTRL_W-1:0] t);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= t;
      do @(posedge clock);
      while (!(csr_valid && csr_ready));
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [cbc_pkg::CTRL_W-1:0] sweep[12];
      sweep = '{cbc_pkg::CTRL_TYPE1_RAM, CTRL_RSVD_7, cbc_pkg::CTRL_NONE, CTRL_RSVD_5,
                CTRL_RSVD_6, cbc_pkg::CTRL_TYPE1_ROM, cbc_pkg::CTRL_TYPE1_ROM,
                cbc_pkg::CTRL_TYPE1_RAM, cbc_pkg::CTRL_TYPE3, cbc_pkg::CTRL_TYPE5,
                cbc_pkg::CTRL_TYPE5, cbc_pkg::CTRL_TYPE3};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // no controller after reset
      queue_write(16'h2000, 8'h05);
      queue_random_writes(WRITES_PER_PHASE);
      wait_idle();

      set_controller_type(cbc_pkg::CTRL_TYPE1_ROM);
      queue_write(16'h0000, 8'h0A);
      queue_write(16'h1FFF, 8'h00);
      queue_write(16'h2000, 8'h00);
      queue_write(16'h4000, 8'h03);
      queue_write(16'h2000, 8'h00);   // zero rom write keeps upper bits
      queue_write(16'h3FFF, 8'hFF);
      queue_write(16'h6000, 8'h01);   // ram banking mode
      queue_write(16'h4000, 8'hFF);
      queue_write(16'h7FFF, 8'h00);   // back to rom banking mode
      queue_write(16'h8000, 8'hFF);
      queue_write(16'hFFFF, 8'h01);
      queue_random_writes(WRITES_PER_PHASE);
      wait_idle();

      set_controller_type(cbc_pkg::CTRL_TYPE3);
      queue_write(16'h2000, 8'h00);
      queue_write(16'h2000, 8'h80);
      queue_write(16'h2000, 8'hFF);
      queue_write(16'h4000, 8'hFF);
      queue_write(16'h6000, 8'h05);   // clock latch
      queue_write(16'h0000, 8'hFF);
      queue_random_writes(WRITES_PER_PHASE);
      wait_idle();

      set_controller_type(cbc_pkg::CTRL_TYPE5);
      hold_requests++;
      queue_write(16'h2000, 8'hFF);
      queue_write(16'h3000, 8'hFF);
      queue_write(16'h2FFF, 8'h00);
      queue_write(16'h4000, 8'hFF);
      queue_write(16'h5FFF, 8'h10);
      queue_write(16'h6000, 8'hAA);
      queue_random_writes(WRITES_PER_PHASE);
      wait_idle();

      foreach (sweep[i]) begin
         set_controller_type(sweep[i]);
         if (i == 6)
            hold_requests++;
         queue_random_writes(WRITES_PER_PHASE);
         wait_idle();
      end

      repeat (8) @(negedge clock);
      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+design
design/cbc_pkg.sv
design/cbc_decode.sv
design/cbc_bank_state.sv
design/cartridge_bank_controller_unit.sv
tb/cartridge_bank_controller_unit_tb.sv
